@@ rtl/gps_pkg.sv @@
`default_nettype none

package gps_pkg;

   // Default fixed point formats.
   localparam int FRAC_BITS_DEF = 16;
   localparam int GRAV_FRAC_DEF = 48;

   // Fixed widths of the payload fields.
   localparam int WORD_W     = 32;
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 128;
   localparam int CSR_ADDR_W = 2;

   // Serial arithmetic widths. The widest product is G*M*S*|d| (32+32+32+33 bits).
   localparam int MUL_W = 129;
   localparam int MPL_W = 64;
   localparam int QUO_W = 34;
   localparam int D2_W  = 65;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_GRAV   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MPP    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PMASS  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_CHK,
      ST_PP,
      ST_BM,
      ST_GM,
      ST_GMS,
      ST_AXM,
      ST_AYM,
      ST_DVX,
      ST_DVY,
      ST_POS,
      ST_OUT
   } state_type;

   // Clips a 36 bit signed sum to 32 bits; the top bit of the result flags a clip.
   function automatic logic [32:0] sat32(input logic signed [35:0] v);
      logic signed [35:0] max_v;
      logic signed [35:0] min_v;
      logic [32:0]        r;
      max_v = 36'sd2147483647;
      min_v = -36'sd2147483648;
      if (v > max_v) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < min_v) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/gps_mul.sv @@
`default_nettype none

// Shift-add multiplier: one multiplier bit per cycle, stops when no set bits remain.
module gps_mul #(
   parameter int MW = gps_pkg::MUL_W,
   parameter int YW = gps_pkg::MPL_W
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [MW-1:0] mcand,
   input  wire logic [YW-1:0] mplier,
   output logic               done,
   output logic [MW-1:0]      product
);

   logic          run_ff;
   logic [MW-1:0] acc_ff;
   logic [MW-1:0] x_ff;
   logic [YW-1:0] y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (run_ff && (y_ff == '0)) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         x_ff   <= mcand;
         y_ff   <= mplier;
      end else if (run_ff && (y_ff != '0)) begin
         if (y_ff[0]) begin
            acc_ff <= acc_ff + x_ff;
         end
         x_ff <= x_ff << 1;
         y_ff <= y_ff >> 1;
      end
   end

   assign done    = run_ff && (y_ff == '0);
   assign product = acc_ff;

endmodule

`default_nettype wire

@@ rtl/gps_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. A quotient that reaches the top
// bit is clipped to exactly that power of two.
module gps_div #(
   parameter int NW = gps_pkg::MUL_W,
   parameter int DW = gps_pkg::MUL_W,
   parameter int QW = gps_pkg::QUO_W
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [QW-1:0]      quot
);

   localparam int SW = DW + QW - 1;
   localparam int CW = (NW > SW) ? NW : SW;
   localparam int KW = $clog2(QW + 1);

   logic          run_ff;
   logic [NW-1:0] rem_ff;
   logic [SW-1:0] ds_ff;
   logic [QW-1:0] q_ff;
   logic [KW-1:0] cnt_ff;
   logic [CW-1:0] rem_w;
   logic [CW-1:0] ds_w;
   logic [CW-1:0] diff_w;
   logic          ge_w;

   assign rem_w  = CW'(rem_ff);
   assign ds_w   = CW'(ds_ff);
   assign ge_w   = rem_w >= ds_w;
   assign diff_w = rem_w - ds_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (run_ff && (cnt_ff == '0)) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         ds_ff  <= {den, {(QW-1){1'b0}}};
         q_ff   <= '0;
         cnt_ff <= KW'(QW);
      end else if (run_ff && (cnt_ff != '0)) begin
         if (ge_w) begin
            rem_ff <= NW'(diff_w);
         end
         q_ff   <= {q_ff[QW-2:0], ge_w};
         ds_ff  <= ds_ff >> 1;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done = run_ff && (cnt_ff == '0);
   assign quot = q_ff[QW-1] ? {1'b1, {(QW-1){1'b0}}} : q_ff;

endmodule

`default_nettype wire

@@ rtl/gravity_particle_step_unit.sv @@
`default_nettype none

// Channel  | Ports                       | Contents (lowest bits first)
// ---------+-----------------------------+-------------------------------------------
// request  | req_tvalid/tready/tdata/tuser | tdata: point_x, point_y, attractor_mass,
//          |                             |   time_step, load_vel_x, load_vel_y;
//          |                             |   tuser: req_type
// response | rsp_tvalid/tready/tdata/tuser | tdata: new_x, new_y, new_vel_x, new_vel_y;
//          |                             |   tuser: captured, saturated
// config   | csr_wen/addr/wdata          | grav_constant, meters_per_pixel,
//          |                             |   capture_radius, particle_mass
//
// A load word passes from the idle state through the result state into the result
// register. A gravity step word runs its squares, products and two divides through
// one shift-add multiplier (one multiplier bit per cycle) and one restoring divider
// (34 quotient bits). Reset is synchronous and clears the particle state and the
// configuration registers to their defaults. A new word is taken whenever the
// sequencer is idle, even while the previous result waits on rsp_tready.
module gravity_particle_step_unit #(
   parameter int FRAC_BITS = gps_pkg::FRAC_BITS_DEF,
   parameter int GRAV_FRAC = gps_pkg::GRAV_FRAC_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // point_x, point_y, attractor_mass, time_step, load_vel_x, load_vel_y
   input  wire logic [gps_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type
   input  wire logic [0:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // new_x, new_y, new_vel_x, new_vel_y
   output logic [gps_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // captured, saturated
   output logic [1:0]                             rsp_tuser,
   input  wire logic                              csr_wen,
   input  wire logic [gps_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [gps_pkg::WORD_W-1:0]        csr_wdata
);

   // The pull is floor((A << 2F) / (B << GF)); only the difference of the shifts
   // matters, so it lands on the numerator or on the denominator.
   localparam int SH  = 2 * FRAC_BITS - GRAV_FRAC;
   localparam int NSH = (SH > 0) ? SH : 0;
   localparam int DSH = (SH < 0) ? -SH : 0;
   localparam int MW  = gps_pkg::MUL_W;
   localparam int YW  = gps_pkg::MPL_W;
   localparam int QW  = gps_pkg::QUO_W;
   localparam int NW  = MW + NSH;
   localparam int DW  = MW + DSH;
   localparam int LW  = gps_pkg::D2_W + 1;

   gps_pkg::state_type state_ff, state_in;

   logic [31:0] grav_ff, mpp_ff, pmass_ff;
   logic [7:0]  rad_ff;

   logic [31:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff;
   logic [31:0] mass_ff, step_ff;
   logic [32:0] ax_ff, ay_ff;
   logic        sx_ff, sy_ff;
   logic [gps_pkg::D2_W-1:0] d2_ff;
   logic [63:0] pp_ff, gm_ff;
   logic [95:0] gms_ff;
   logic [MW-1:0] b_ff, nx_ff, ny_ff;
   logic        cap_ff, sat_ff, issued_ff;

   logic        rsp_valid_ff;
   logic [gps_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   logic        req_acc;
   logic        out_free;
   logic        is_mul, is_div;
   logic        mul_start, mul_done, div_start, div_done;
   logic [MW-1:0] mul_mcand, mul_product;
   logic [YW-1:0] mul_mplier;
   logic [MW-1:0] num_sel;
   logic [NW-1:0] div_num;
   logic [DW-1:0] div_den;
   logic [QW-1:0] div_quot;

   logic signed [32:0] dx_w, dy_w;
   logic [15:0] r2_w;
   logic [LW-1:0] lim_w;
   logic        cap_w, zero_w, pull_en;
   logic [35:0] qext_w, addend_w, vsum_w;
   logic [31:0] vel_sel;
   logic        sgn_sel;
   logic [32:0] vsat_w, nx_sat_w, ny_sat_w, px_sat_w, py_sat_w;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == gps_pkg::ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Offsets to the attractor are taken at acceptance against the current position.
   assign dx_w = $signed({req_tdata[31], req_tdata[31:0]}) - $signed({pos_x_ff[31], pos_x_ff});
   assign dy_w = $signed({req_tdata[63], req_tdata[63:32]}) - $signed({pos_y_ff[31], pos_y_ff});

   assign r2_w    = {8'd0, rad_ff} * {8'd0, rad_ff};
   assign lim_w   = LW'(r2_w) << (2 * FRAC_BITS);
   assign cap_w   = LW'(d2_ff) <= lim_w;
   assign zero_w  = (ax_ff == '0) && (ay_ff == '0);
   assign pull_en = (pmass_ff != '0) && (mpp_ff != '0);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff  <= '0;
         mpp_ff   <= 32'd65536;
         rad_ff   <= 8'd5;
         pmass_ff <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            gps_pkg::CSR_GRAV:   grav_ff  <= csr_wdata;
            gps_pkg::CSR_MPP:    mpp_ff   <= csr_wdata;
            gps_pkg::CSR_RADIUS: rad_ff   <= csr_wdata[7:0];
            gps_pkg::CSR_PMASS:  pmass_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      is_mul     = 1'b0;
      mul_mcand  = '0;
      mul_mplier = '0;
      case (state_ff)
         gps_pkg::ST_SQX: begin
            is_mul = 1'b1; mul_mcand = MW'(ax_ff); mul_mplier = YW'(ax_ff);
         end
         gps_pkg::ST_SQY: begin
            is_mul = 1'b1; mul_mcand = MW'(ay_ff); mul_mplier = YW'(ay_ff);
         end
         gps_pkg::ST_PP: begin
            is_mul = 1'b1; mul_mcand = MW'(mpp_ff); mul_mplier = YW'(mpp_ff);
         end
         gps_pkg::ST_BM: begin
            is_mul = 1'b1; mul_mcand = MW'(d2_ff); mul_mplier = pp_ff;
         end
         gps_pkg::ST_GM: begin
            is_mul = 1'b1; mul_mcand = MW'(grav_ff); mul_mplier = YW'(mass_ff);
         end
         gps_pkg::ST_GMS: begin
            is_mul = 1'b1; mul_mcand = MW'(gm_ff); mul_mplier = YW'(step_ff);
         end
         gps_pkg::ST_AXM: begin
            is_mul = 1'b1; mul_mcand = MW'(gms_ff); mul_mplier = YW'(ax_ff);
         end
         gps_pkg::ST_AYM: begin
            is_mul = 1'b1; mul_mcand = MW'(gms_ff); mul_mplier = YW'(ay_ff);
         end
         default: begin
         end
      endcase
   end

   assign is_div    = (state_ff == gps_pkg::ST_DVX) || (state_ff == gps_pkg::ST_DVY);
   assign mul_start = is_mul && !issued_ff;
   assign div_start = is_div && !issued_ff;
   assign num_sel   = (state_ff == gps_pkg::ST_DVY) ? ny_ff : nx_ff;
   assign div_num   = NW'(num_sel) << NSH;
   assign div_den   = DW'(b_ff) << DSH;

   gps_mul #(
      .MW (MW),
      .YW (YW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_product)
   );

   gps_div #(
      .NW (NW),
      .DW (DW),
      .QW (QW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Velocity plus the signed pull increment, and the position sums.
   assign vel_sel  = (state_ff == gps_pkg::ST_DVY) ? vel_y_ff : vel_x_ff;
   assign sgn_sel  = (state_ff == gps_pkg::ST_DVY) ? sy_ff : sx_ff;
   assign qext_w   = {2'b00, div_quot};
   assign addend_w = sgn_sel ? (36'd0 - qext_w) : qext_w;
   assign vsum_w   = {{4{vel_sel[31]}}, vel_sel} + addend_w;
   assign vsat_w   = gps_pkg::sat32(vsum_w);
   assign nx_sat_w = gps_pkg::sat32(36'd0 - {{4{vel_x_ff[31]}}, vel_x_ff});
   assign ny_sat_w = gps_pkg::sat32(36'd0 - {{4{vel_y_ff[31]}}, vel_y_ff});
   assign px_sat_w = gps_pkg::sat32({{4{pos_x_ff[31]}}, pos_x_ff}
                                    + {{4{vel_x_ff[31]}}, vel_x_ff});
   assign py_sat_w = gps_pkg::sat32({{4{pos_y_ff[31]}}, pos_y_ff}
                                    + {{4{vel_y_ff[31]}}, vel_y_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gps_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = req_tuser[0] ? gps_pkg::ST_OUT : gps_pkg::ST_SQX;
            end
         end
         gps_pkg::ST_SQX: if (mul_done) state_in = gps_pkg::ST_SQY;
         gps_pkg::ST_SQY: if (mul_done) state_in = gps_pkg::ST_CHK;
         gps_pkg::ST_CHK: begin
            if (cap_w || !pull_en) begin
               state_in = gps_pkg::ST_POS;
            end else begin
               state_in = gps_pkg::ST_PP;
            end
         end
         gps_pkg::ST_PP:  if (mul_done) state_in = gps_pkg::ST_BM;
         gps_pkg::ST_BM:  if (mul_done) state_in = gps_pkg::ST_GM;
         gps_pkg::ST_GM:  if (mul_done) state_in = gps_pkg::ST_GMS;
         gps_pkg::ST_GMS: if (mul_done) state_in = gps_pkg::ST_AXM;
         gps_pkg::ST_AXM: if (mul_done) state_in = gps_pkg::ST_AYM;
         gps_pkg::ST_AYM: if (mul_done) state_in = gps_pkg::ST_DVX;
         gps_pkg::ST_DVX: if (div_done) state_in = gps_pkg::ST_DVY;
         gps_pkg::ST_DVY: if (div_done) state_in = gps_pkg::ST_POS;
         gps_pkg::ST_POS: state_in = gps_pkg::ST_OUT;
         gps_pkg::ST_OUT: if (out_free) state_in = gps_pkg::ST_IDLE;
         default:         state_in = gps_pkg::ST_IDLE;
      endcase
   end

   // A unit is started once on entry to its state and rearmed when it finishes.
   always_ff @(posedge clock) begin
      if (reset) begin
         issued_ff <= 1'b0;
      end else if (mul_start || div_start) begin
         issued_ff <= 1'b1;
      end else if (mul_done || div_done) begin
         issued_ff <= 1'b0;
      end
   end

   // Particle state and flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         cap_ff   <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         case (state_ff)
            gps_pkg::ST_IDLE: begin
               if (req_acc) begin
                  cap_ff <= 1'b0;
                  sat_ff <= 1'b0;
                  if (req_tuser[0]) begin
                     pos_x_ff <= req_tdata[31:0];
                     pos_y_ff <= req_tdata[63:32];
                     vel_x_ff <= req_tdata[159:128];
                     vel_y_ff <= req_tdata[191:160];
                  end
               end
            end
            gps_pkg::ST_CHK: begin
               if (cap_w) begin
                  cap_ff <= 1'b1;
                  // At exactly zero distance the particle bounces back.
                  if (zero_w) begin
                     vel_x_ff <= nx_sat_w[31:0];
                     vel_y_ff <= ny_sat_w[31:0];
                     sat_ff   <= nx_sat_w[32] || ny_sat_w[32];
                  end
               end
            end
            gps_pkg::ST_DVX: begin
               if (div_done) begin
                  vel_x_ff <= vsat_w[31:0];
                  sat_ff   <= sat_ff || vsat_w[32];
               end
            end
            gps_pkg::ST_DVY: begin
               if (div_done) begin
                  vel_y_ff <= vsat_w[31:0];
                  sat_ff   <= sat_ff || vsat_w[32];
               end
            end
            gps_pkg::ST_POS: begin
               pos_x_ff <= px_sat_w[31:0];
               pos_y_ff <= py_sat_w[31:0];
               sat_ff   <= sat_ff || px_sat_w[32] || py_sat_w[32];
            end
            default: begin
            end
         endcase
      end
   end

   // Working registers of the step.
   always_ff @(posedge clock) begin
      if ((state_ff == gps_pkg::ST_IDLE) && req_acc) begin
         mass_ff <= req_tdata[95:64];
         step_ff <= req_tdata[127:96];
         sx_ff   <= dx_w[32];
         sy_ff   <= dy_w[32];
         ax_ff   <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
         ay_ff   <= dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
      end
      if (mul_done) begin
         case (state_ff)
            gps_pkg::ST_SQX: d2_ff  <= gps_pkg::D2_W'(mul_product);
            gps_pkg::ST_SQY: d2_ff  <= d2_ff + gps_pkg::D2_W'(mul_product);
            gps_pkg::ST_PP:  pp_ff  <= 64'(mul_product);
            gps_pkg::ST_BM:  b_ff   <= mul_product;
            gps_pkg::ST_GM:  gm_ff  <= 64'(mul_product);
            gps_pkg::ST_GMS: gms_ff <= 96'(mul_product);
            gps_pkg::ST_AXM: nx_ff  <= mul_product;
            gps_pkg::ST_AYM: ny_ff  <= mul_product;
            default: begin
            end
         endcase
      end
   end

   // Result register: holds one word so the sequencer can take the next request.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == gps_pkg::ST_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == gps_pkg::ST_OUT) && out_free) begin
         rsp_data_ff <= {vel_y_ff, vel_x_ff, pos_y_ff, pos_x_ff};
         rsp_user_ff <= {sat_ff, cap_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef ASSERT_OFF
   a_mul_done_in_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> is_mul)
      else $error("multiplier finished outside a multiply state");

   a_div_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == gps_pkg::ST_DVX) || (state_ff == gps_pkg::ST_DVY)))
      else $error("divider finished outside a divide state");

   a_load_goes_out: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0]) |=> (state_ff == gps_pkg::ST_OUT))
      else $error("load word did not go straight to the result stage");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == gps_pkg::ST_OUT) && rsp_tvalid && !rsp_tready)
      |=> (state_ff == gps_pkg::ST_OUT))
      else $error("result stage left while the previous word was still held");
`endif

endmodule

`default_nettype wire
